// File: hdl/mspb_pkg.sv
// Package for the multichannel soft PWM and blink generator.
// Holds the opcode and pin mode codes and the sequencer state type.
// It has no dependencies.
package mspb_pkg;

   typedef enum logic [3:0] {
      OP_TICK       = 4'd0,
      OP_WRITE_HIGH = 4'd1,
      OP_WRITE_LOW  = 4'd2,
      OP_TOGGLE     = 4'd3,
      OP_TURN_ON    = 4'd4,
      OP_TURN_OFF   = 4'd5,
      OP_MODE_IN    = 4'd6,
      OP_MODE_PULL  = 4'd7,
      OP_MODE_OUT   = 4'd8,
      OP_PWM_PERIOD = 4'd9,
      OP_BLINK_ON   = 4'd10,
      OP_BLINK_OFF  = 4'd11,
      OP_SYNC       = 4'd12,
      OP_SET_UNIT   = 4'd13,
      OP_RESET_ALL  = 4'd14,
      OP_UNKNOWN    = 4'd15
   } opcode_type;

   typedef enum logic [1:0] {
      MODE_OUT    = 2'd0,
      MODE_IN     = 2'd1,
      MODE_PULLUP = 2'd2
   } pin_mode_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_UNKNOWN = 2'd1,
      ST_REFUSED = 2'd2
   } status_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_CMD,
      S_MUL,
      S_DIV,
      S_SCAN,
      S_DONE
   } seq_state_type;

   // The on-time is formed as (period / 100) * duty + ((period % 100) * duty) / 100.
   // Both divisions by one hundred use reciprocal multiplication.
   localparam int MUL_STEPS = 4;
   localparam logic [31:0] RECIP_100 = 32'h51EB_851F;
   localparam int RECIP_SHIFT = 37;
   localparam logic [31:0] FRAC_RECIP = 32'd5243;
   localparam int FRAC_SHIFT = 19;
   localparam logic [30:0] MAX31 = 31'h7FFF_FFFF;
   localparam logic [6:0]  DUTY_MAX = 7'd100;
   localparam logic [6:0]  DUTY_BLINK = 7'd50;
   localparam logic [7:0]  DIVISOR = 8'd100;

endpackage

// File: hdl/multichannel_soft_pwm_blinker_unit.sv
// Top level of the multichannel soft PWM and blink generator.
// Per-channel state, a small sequencer and a shared multiplier.
// Depends on mspb_pkg.
//
// Usage: the req channel carries one word per tick or command; its tdata
// packs opcode, channel, value_one, value_two, now_millis and now_micros.
// The rsp channel returns exactly one word per request: the level of every
// channel after the request and a status code.
// Flow: a plain command goes from S_CMD straight to S_DONE. A tick or a sync
// visits the channels one per cycle in S_SCAN. A PWM or blink start takes
// one reciprocal step and four further passes through the shared multiplier
// that form the on-time.
// One request is in work at a time; req_tready is high only while idle.
// A finished response waits in the output register; if the receiver stalls,
// the sequencer holds the next result until that register is taken.
// Reset clears all channel state to output mode, low level, milliseconds.
module multichannel_soft_pwm_blinker_unit
   import mspb_pkg::*;
#(
   parameter int CHANNELS      = 20,
   parameter int DIGITAL_LIMIT = 14
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // Fields from bit 0: opcode, channel, value_one, value_two,
   // now_millis, now_micros.
   input  logic [111:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // Fields from bit 0: pin_levels, status, two zero bits.
   output logic [23:0]  rsp_tdata
);

   localparam int CHW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam logic [CHW-1:0] LAST_CH = CHW'(CHANNELS - 1);

   seq_state_type state_ff, state_in;

   logic [3:0]  op_ff;
   logic [4:0]  ch_ff;
   logic [30:0] v1_ff;
   logic [7:0]  v2_ff;
   logic [31:0] ms_ff, us_ff;

   logic [31:0] start_ff [CHANNELS];
   logic [31:0] start_in [CHANNELS];
   logic [30:0] period_ff [CHANNELS];
   logic [30:0] period_in [CHANNELS];
   logic [30:0] onlen_ff [CHANNELS];
   logic [30:0] onlen_in [CHANNELS];
   logic [6:0]  duty_ff [CHANNELS];
   logic [6:0]  duty_in [CHANNELS];
   pin_mode_type mode_ff [CHANNELS];
   pin_mode_type mode_in [CHANNELS];
   logic [CHANNELS-1:0] blink_ff, blink_in;
   logic [CHANNELS-1:0] hpw_ff, hpw_in;
   logic [CHANNELS-1:0] level_ff, level_in;
   logic [CHANNELS-1:0] micro_ff, micro_in;

   logic [CHW-1:0] cnt_ff, cnt_in;
   logic [1:0]  dcnt_ff, dcnt_in;
   logic [30:0] dvd_ff, dvd_in;
   logic [6:0]  rem_ff, rem_in;
   logic [13:0] frac_ff, frac_in;
   logic [30:0] pper_ff, pper_in;
   logic [6:0]  pduty_ff, pduty_in;
   status_type  stat_ff, stat_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [19:0] rsp_lvl_ff, rsp_lvl_in;
   status_type  rsp_stat_ff, rsp_stat_in;

   logic           addressed, ch_ok;
   logic [CHW-1:0] idx, sidx;
   logic [31:0]    now_c, now_s, elapsed;
   logic [31:0]    mul_a, mul_b;
   logic [63:0]    mul_p;
   logic [30:0]    rem_full;
   logic           load_rsp;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_stat_ff, rsp_lvl_ff};

   assign addressed = !(op_ff == OP_TICK || op_ff == OP_SYNC || op_ff == OP_RESET_ALL
                        || op_ff == OP_UNKNOWN);
   assign ch_ok   = (ch_ff < 5'(CHANNELS));
   assign idx     = ch_ok ? ch_ff[CHW-1:0] : '0;
   assign sidx    = cnt_ff;
   assign now_c   = micro_ff[idx] ? us_ff : ms_ff;
   assign now_s   = micro_ff[sidx] ? us_ff : ms_ff;
   assign elapsed = now_s - start_ff[sidx];
   assign mul_p    = 64'(mul_a) * 64'(mul_b);
   assign rem_full = pper_ff - mul_p[30:0];
   assign load_rsp = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_tready);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: if (req_tvalid) state_in = S_CMD;
         S_CMD: begin
            if (addressed && !ch_ok) begin
               state_in = S_DONE;
            end else if (op_ff == OP_TICK || op_ff == OP_SYNC) begin
               state_in = S_SCAN;
            end else if (op_ff == OP_PWM_PERIOD || op_ff == OP_BLINK_ON) begin
               state_in = S_MUL;
            end else begin
               state_in = S_DONE;
            end
         end
         S_MUL:  state_in = S_DIV;
         S_DIV:  if (dcnt_ff == 2'(MUL_STEPS - 1)) state_in = S_DONE;
         S_SCAN: if (cnt_ff == LAST_CH) state_in = S_DONE;
         S_DONE: if (load_rsp) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      if (state_ff == S_MUL) begin
         mul_a = {1'b0, pper_ff};
         mul_b = RECIP_100;
      end else if (state_ff == S_DIV) begin
         unique case (dcnt_ff)
            2'd0: begin
               mul_a = {1'b0, dvd_ff};
               mul_b = {24'd0, DIVISOR};
            end
            2'd1: begin
               mul_a = {1'b0, dvd_ff};
               mul_b = {25'd0, pduty_ff};
            end
            2'd2: begin
               mul_a = {25'd0, rem_ff};
               mul_b = {25'd0, pduty_ff};
            end
            2'd3: begin
               mul_a = {18'd0, frac_ff};
               mul_b = FRAC_RECIP;
            end
         endcase
      end
   end

   always_comb begin
      start_in  = start_ff;
      period_in = period_ff;
      onlen_in  = onlen_ff;
      duty_in   = duty_ff;
      mode_in   = mode_ff;
      blink_in  = blink_ff;
      hpw_in    = hpw_ff;
      level_in  = level_ff;
      micro_in  = micro_ff;
      cnt_in    = cnt_ff;
      dcnt_in   = dcnt_ff;
      dvd_in    = dvd_ff;
      rem_in    = rem_ff;
      frac_in   = frac_ff;
      pper_in   = pper_ff;
      pduty_in  = pduty_ff;
      stat_in   = stat_ff;
      unique case (state_ff)
         S_IDLE: begin
            stat_in = ST_OK;
            cnt_in  = '0;
            dcnt_in = '0;
         end
         S_CMD: begin
            if (addressed && !ch_ok) begin
               stat_in = ST_REFUSED;
            end else begin
               unique case (op_ff)
                  OP_TICK, OP_SYNC: ;
                  OP_WRITE_HIGH, OP_WRITE_LOW: begin
                     blink_in[idx] = 1'b0;
                     start_in[idx] = '0;
                     hpw_in[idx]   = 1'b0;
                     mode_in[idx]  = MODE_OUT;
                     level_in[idx] = (op_ff == OP_WRITE_HIGH);
                  end
                  OP_TOGGLE: begin
                     if (mode_ff[idx] == MODE_OUT) level_in[idx] = !level_ff[idx];
                     else stat_in = ST_REFUSED;
                  end
                  OP_TURN_ON, OP_TURN_OFF: begin
                     if (ch_ff < 5'(DIGITAL_LIMIT)) begin
                        blink_in[idx] = 1'b0;
                        start_in[idx] = '0;
                        hpw_in[idx]   = 1'b0;
                        mode_in[idx]  = MODE_OUT;
                        level_in[idx] = (op_ff == OP_TURN_ON);
                     end else begin
                        stat_in = ST_REFUSED;
                     end
                  end
                  OP_MODE_IN, OP_MODE_PULL, OP_MODE_OUT, OP_BLINK_OFF: begin
                     blink_in[idx] = 1'b0;
                     start_in[idx] = '0;
                     hpw_in[idx]   = 1'b0;
                     mode_in[idx]  = (op_ff == OP_MODE_IN) ? MODE_IN :
                                     (op_ff == OP_MODE_PULL) ? MODE_PULLUP : MODE_OUT;
                  end
                  OP_PWM_PERIOD: begin
                     pper_in  = v1_ff;
                     pduty_in = (v2_ff > 8'(DUTY_MAX)) ? DUTY_MAX : v2_ff[6:0];
                  end
                  OP_BLINK_ON: begin
                     pper_in  = v1_ff[30] ? MAX31 : {v1_ff[29:0], 1'b0};
                     pduty_in = DUTY_BLINK;
                  end
                  OP_SET_UNIT: begin
                     micro_in[idx] = (v1_ff != '0);
                     if (blink_ff[idx]) begin
                        start_in[idx] = (v1_ff != '0) ? us_ff : ms_ff;
                        hpw_in[idx]   = 1'b0;
                     end
                  end
                  OP_RESET_ALL: begin
                     blink_in = '0;
                     hpw_in   = '0;
                     level_in = '0;
                     micro_in = '0;
                     for (int c = 0; c < CHANNELS; c++) begin
                        start_in[c] = '0;
                        mode_in[c]  = MODE_OUT;
                     end
                  end
                  default: stat_in = ST_UNKNOWN;
               endcase
            end
         end
         S_MUL: begin
            dvd_in = 31'(mul_p[63:RECIP_SHIFT]);
            rem_in = '0;
         end
         S_DIV: begin
            dcnt_in = dcnt_ff + 2'd1;
            unique case (dcnt_ff)
               2'd0: rem_in = rem_full[6:0];
               2'd1: dvd_in = mul_p[30:0];
               2'd2: frac_in = mul_p[13:0];
               2'd3: begin
                  blink_in[idx]  = 1'b1;
                  hpw_in[idx]    = 1'b0;
                  mode_in[idx]   = MODE_OUT;
                  start_in[idx]  = now_c;
                  period_in[idx] = pper_ff;
                  duty_in[idx]   = pduty_ff;
                  onlen_in[idx]  = dvd_ff + 31'(mul_p[FRAC_SHIFT+6:FRAC_SHIFT]);
               end
            endcase
         end
         S_SCAN: begin
            cnt_in = cnt_ff + 1'b1;
            if (blink_ff[sidx]) begin
               if (op_ff == OP_SYNC) begin
                  start_in[sidx] = now_s;
                  hpw_in[sidx]   = 1'b0;
                  mode_in[sidx]  = MODE_OUT;
               end else if (elapsed < {1'b0, onlen_ff[sidx]}) begin
                  if (!hpw_ff[sidx]) begin
                     level_in[sidx] = 1'b1;
                     hpw_in[sidx]   = 1'b1;
                  end
               end else if (elapsed < {1'b0, period_ff[sidx]}) begin
                  if (hpw_ff[sidx]) begin
                     level_in[sidx] = 1'b0;
                     hpw_in[sidx]   = 1'b0;
                  end
               end else begin
                  start_in[sidx] = now_s;
               end
            end
         end
         S_DONE: ;
         default: ;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_lvl_in   = rsp_lvl_ff;
      rsp_stat_in  = rsp_stat_ff;
      if (rsp_valid_ff && rsp_tready) rsp_valid_in = 1'b0;
      if (load_rsp) begin
         rsp_valid_in = 1'b1;
         rsp_lvl_in   = 20'(level_ff);
         rsp_stat_in  = stat_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         blink_ff     <= '0;
         hpw_ff       <= '0;
         level_ff     <= '0;
         micro_ff     <= '0;
         cnt_ff       <= '0;
         dcnt_ff      <= '0;
         for (int c = 0; c < CHANNELS; c++) begin
            start_ff[c]  <= '0;
            period_ff[c] <= '0;
            onlen_ff[c]  <= '0;
            duty_ff[c]   <= '0;
            mode_ff[c]   <= MODE_OUT;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         blink_ff     <= blink_in;
         hpw_ff       <= hpw_in;
         level_ff     <= level_in;
         micro_ff     <= micro_in;
         cnt_ff       <= cnt_in;
         dcnt_ff      <= dcnt_in;
         start_ff     <= start_in;
         period_ff    <= period_in;
         onlen_ff     <= onlen_in;
         duty_ff      <= duty_in;
         mode_ff      <= mode_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         op_ff <= req_tdata[3:0];
         ch_ff <= req_tdata[8:4];
         v1_ff <= req_tdata[39:9];
         v2_ff <= req_tdata[47:40];
         ms_ff <= req_tdata[79:48];
         us_ff <= req_tdata[111:80];
      end
      dvd_ff      <= dvd_in;
      rem_ff      <= rem_in;
      frac_ff     <= frac_in;
      pper_ff     <= pper_in;
      pduty_ff    <= pduty_in;
      stat_ff     <= stat_in;
      rsp_lvl_ff  <= rsp_lvl_in;
      rsp_stat_ff <= rsp_stat_in;
   end

   a_div_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DIV && dcnt_ff == 2'(MUL_STEPS - 1) |=> state_ff == S_DONE)
      else $error("Multiplier sequence ran past its last step.");

   a_scan_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SCAN |-> cnt_ff <= LAST_CH)
      else $error("Channel scan index out of range.");

   a_blink_out: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SCAN && blink_ff[sidx] |-> mode_ff[sidx] == MODE_OUT)
      else $error("Active channel is not in output mode.");

   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("Request taken while a request is in work.");

   a_rem: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_DIV |-> rem_ff < DUTY_MAX)
      else $error("Divider remainder reached the divisor.");

endmodule

// File: bench/tb.sv
// Self-checking bench for the multichannel soft PWM and blink generator.
// Drives command and tick words, predicts the level and status word for each one, and compares.
// Depends on mspb_pkg and multichannel_soft_pwm_blinker_unit.
module tb;
   import mspb_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int NCH = 20;
   localparam int NDIG = 14;
   localparam int RANDOM_WORDS = 1830;
   localparam longint CYCLE_LIMIT = 400000;

   typedef struct packed {
      logic [31:0] micros;
      logic [31:0] millis;
      logic [7:0]  duty;
      logic [30:0] value;
      logic [4:0]  chan;
      logic [3:0]  op;
   } cmd_word_t;

   typedef struct {
      cmd_word_t   cmd;
      logic        known;
      logic [19:0] levels;
      status_type  status;
   } table_row_t;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [111:0] req_tdata;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [23:0]  rsp_tdata;

   multichannel_soft_pwm_blinker_unit uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );

   // Predicted channel state.
   logic [31:0]  ch_start [NCH];
   logic [30:0]  ch_period [NCH];
   logic [30:0]  ch_on [NCH];
   logic [6:0]   ch_duty [NCH];
   logic         ch_active [NCH];
   logic         ch_high [NCH];
   logic         ch_level [NCH];
   pin_mode_type ch_mode [NCH];
   logic         ch_micro [NCH];

   logic [21:0]  level_queue [$];
   int           mismatches = 0;
   longint       cycles = 0;
   bit           stim_done = 0;
   bit           long_hold = 0;
   table_row_t   rows [$];
   logic [31:0]  ms_now = 0;
   logic [31:0]  us_now = 0;

   function automatic logic [31:0] chan_time(int c, cmd_word_t w);
      return ch_micro[c] ? w.micros : w.millis;
   endfunction

   function automatic void clear_chan(int c, pin_mode_type m);
      ch_active[c] = 0;
      ch_start[c] = 0;
      ch_high[c] = 0;
      ch_mode[c] = m;
   endfunction

   function automatic void begin_pwm(int c, logic [30:0] per, int unsigned duty,
                                     logic [31:0] t);
      logic [63:0] prod;
      if (duty > 100) duty = 100;
      clear_chan(c, MODE_OUT);
      ch_period[c] = per;
      ch_duty[c] = duty[6:0];
      ch_start[c] = t;
      prod = 64'(per) * 64'(duty);
      ch_on[c] = 31'(prod / 100);
      ch_active[c] = 1;
   endfunction

   function automatic void reset_levels();
      for (int c = 0; c < NCH; c++) begin
         ch_micro[c] = 0;
         clear_chan(c, MODE_OUT);
         ch_level[c] = 0;
         ch_period[c] = 0;
         ch_on[c] = 0;
         ch_duty[c] = 0;
      end
   endfunction

   function automatic logic [21:0] predict_levels(cmd_word_t w);
      status_type st;
      logic [19:0] lv;
      logic [31:0] t, el;
      logic [31:0] dbl;
      int c;
      bit addressed;
      st = ST_OK;
      c = w.chan;
      addressed = !(w.op inside {OP_TICK, OP_SYNC, OP_RESET_ALL, OP_UNKNOWN});
      if (addressed && w.chan >= NCH) st = ST_REFUSED;
      else begin
         case (opcode_type'(w.op))
            OP_TICK: begin
               for (int k = 0; k < NCH; k++) begin
                  if (ch_active[k]) begin
                     t = chan_time(k, w);
                     el = t - ch_start[k];
                     if (el < {1'b0, ch_on[k]}) begin
                        if (!ch_high[k]) begin
                           ch_level[k] = 1;
                           ch_high[k] = 1;
                        end
                     end else if (el < {1'b0, ch_period[k]}) begin
                        if (ch_high[k]) begin
                           ch_level[k] = 0;
                           ch_high[k] = 0;
                        end
                     end else ch_start[k] = t;
                  end
               end
            end
            OP_WRITE_HIGH, OP_WRITE_LOW: begin
               clear_chan(c, MODE_OUT);
               ch_level[c] = (w.op == OP_WRITE_HIGH);
            end
            OP_TOGGLE: begin
               if (ch_mode[c] == MODE_OUT) ch_level[c] = !ch_level[c];
               else st = ST_REFUSED;
            end
            OP_TURN_ON, OP_TURN_OFF: begin
               if (c < NDIG) begin
                  clear_chan(c, MODE_OUT);
                  ch_level[c] = (w.op == OP_TURN_ON);
               end else st = ST_REFUSED;
            end
            OP_MODE_IN: clear_chan(c, MODE_IN);
            OP_MODE_PULL: clear_chan(c, MODE_PULLUP);
            OP_MODE_OUT, OP_BLINK_OFF: clear_chan(c, MODE_OUT);
            OP_PWM_PERIOD: begin_pwm(c, w.value, w.duty, chan_time(c, w));
            OP_BLINK_ON: begin
               dbl = {w.value, 1'b0};
               if (dbl > 32'h7FFF_FFFF) dbl = 32'h7FFF_FFFF;
               begin_pwm(c, dbl[30:0], 50, chan_time(c, w));
            end
            OP_SYNC: begin
               for (int k = 0; k < NCH; k++)
                  if (ch_active[k])
                     begin_pwm(k, ch_period[k], ch_duty[k], chan_time(k, w));
            end
            OP_SET_UNIT: begin
               ch_micro[c] = (w.value != 0);
               if (ch_active[c]) begin
                  ch_start[c] = chan_time(c, w);
                  ch_high[c] = 0;
               end
            end
            OP_RESET_ALL: begin
               for (int k = 0; k < NCH; k++) begin
                  ch_micro[k] = 0;
                  clear_chan(k, MODE_OUT);
                  ch_level[k] = 0;
               end
            end
            default: st = ST_UNKNOWN;
         endcase
      end
      for (int k = 0; k < NCH; k++) lv[k] = ch_level[k];
      return {st, lv};
   endfunction

   initial begin
      clock = 0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("multichannel_soft_pwm_blinker_unit regression: fail");
         $finish;
      end
   end

   // Receiver: own stall pattern, plus one long hold-off.
   initial begin
      int pat;
      rsp_tready = 0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         pat = $urandom_range(0, 3);
         for (int i = 0; i < 40; i++) begin
            @(negedge clock);
            if (long_hold) rsp_tready <= 0;
            else case (pat)
               0: rsp_tready <= 1;
               1: rsp_tready <= ($urandom_range(0, 3) != 0);
               2: rsp_tready <= (i % 3 == 0);
               default: rsp_tready <= ($urandom_range(0, 1) != 0);
            endcase
         end
      end
   end

   initial begin
      wait (stim_done == 0 && cycles > 600);
      long_hold = 1;
      repeat (300) @(negedge clock);
      long_hold = 0;
   end

   // Response checker.
   always @(posedge clock) begin
      logic [21:0] exp_w;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (level_queue.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected word %h", rsp_tdata);
         end else begin
            exp_w = level_queue.pop_front();
            if (rsp_tdata[19:0] !== exp_w[19:0] || rsp_tdata[21:20] !== exp_w[21:20]) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("mismatch: levels exp %h got %h, status exp %0d got %0d",
                           exp_w[19:0], rsp_tdata[19:0], exp_w[21:20], rsp_tdata[21:20]);
            end
         end
      end
   end

   task automatic send_word(cmd_word_t w, logic known, logic [19:0] lv, status_type st);
      logic [21:0] p;
      req_tvalid <= 1;
      req_tdata <= w;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      p = predict_levels(w);
      if (known && p !== {st, lv}) begin
         mismatches++;
         if (mismatches <= 10) $display("table row disagrees: %h vs %h", p, {st, lv});
      end
      level_queue.push_back(p);
      @(negedge clock);
   endtask

   function automatic cmd_word_t make_word(opcode_type op, int c, logic [30:0] v,
                                           logic [7:0] d);
      cmd_word_t w;
      w.op = op; w.chan = 5'(c); w.value = v; w.duty = d;
      w.millis = ms_now; w.micros = us_now;
      return w;
   endfunction

   function automatic void add_row(opcode_type op, int c, logic [30:0] v, logic [7:0] d,
                                   logic known, logic [19:0] lv, status_type st);
      table_row_t r;
      r.cmd = make_word(op, c, v, d);
      r.known = known; r.levels = lv; r.status = st;
      rows.push_back(r);
   endfunction

   function automatic cmd_word_t random_word();
      cmd_word_t w;
      int r;
      r = $urandom_range(0, 99);
      ms_now += $urandom_range(0, 3);
      us_now += $urandom_range(1, 900);
      if ($urandom_range(0, 199) == 0) begin
         ms_now = $urandom; us_now = $urandom;
      end
      w.op = (r < 45) ? OP_TICK : 4'($urandom_range(0, 15));
      w.chan = ($urandom_range(0, 9) == 0) ? 5'($urandom_range(0, 31))
                                           : 5'($urandom_range(0, NCH - 1));
      case ($urandom_range(0, 3))
         0: w.value = 31'($urandom_range(0, 12));
         1: w.value = 31'($urandom_range(1, 3000));
         2: w.value = 31'($urandom);
         default: w.value = 31'h7FFF_FFFF - 31'($urandom_range(0, 3));
      endcase
      w.duty = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                           : 8'($urandom_range(0, 100));
      w.millis = ms_now; w.micros = us_now;
      if ($urandom_range(0, 49) == 0) begin
         w.millis = $urandom; w.micros = $urandom;
      end
      return w;
   endfunction

   initial begin
      int gap;
      reset = 1;
      req_tvalid = 0;
      req_tdata = '0;
      reset_levels();
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 0;

      add_row(OP_TICK, 0, 0, 0, 1, 20'h0, ST_OK);
      add_row(OP_WRITE_HIGH, 0, 0, 0, 1, 20'h1, ST_OK);
      add_row(OP_WRITE_HIGH, 19, 0, 0, 1, 20'h80001, ST_OK);
      add_row(OP_WRITE_LOW, 19, 0, 0, 1, 20'h1, ST_OK);
      add_row(OP_TOGGLE, 5, 0, 0, 1, 20'h21, ST_OK);
      add_row(OP_TURN_ON, 13, 0, 0, 1, 20'h2021, ST_OK);
      add_row(OP_TURN_ON, 14, 0, 0, 1, 20'h2021, ST_REFUSED);
      add_row(OP_TURN_OFF, 13, 0, 0, 1, 20'h21, ST_OK);
      add_row(OP_MODE_IN, 5, 0, 0, 1, 20'h21, ST_OK);
      add_row(OP_TOGGLE, 5, 0, 0, 1, 20'h21, ST_REFUSED);
      add_row(OP_MODE_PULL, 6, 0, 0, 1, 20'h21, ST_OK);
      add_row(OP_MODE_OUT, 5, 0, 0, 1, 20'h21, ST_OK);
      add_row(OP_WRITE_HIGH, 20, 0, 0, 1, 20'h21, ST_REFUSED);
      add_row(OP_TOGGLE, 31, 0, 0, 1, 20'h21, ST_REFUSED);
      add_row(OP_UNKNOWN, 0, 0, 0, 1, 20'h21, ST_UNKNOWN);
      add_row(OP_PWM_PERIOD, 2, 31'h7FFF_FFFF, 8'hFF, 0, 0, ST_OK);
      add_row(OP_PWM_PERIOD, 3, 0, 50, 0, 0, ST_OK);
      add_row(OP_BLINK_ON, 4, 31'h7FFF_FFFF, 0, 0, 0, ST_OK);
      add_row(OP_SET_UNIT, 4, 1, 0, 0, 0, ST_OK);
      add_row(OP_TICK, 0, 0, 0, 0, 0, ST_OK);
      add_row(OP_SYNC, 0, 0, 0, 0, 0, ST_OK);
      add_row(OP_BLINK_OFF, 2, 0, 0, 0, 0, ST_OK);
      add_row(OP_TICK, 0, 0, 0, 0, 0, ST_OK);
      add_row(OP_RESET_ALL, 0, 0, 0, 1, 20'h0, ST_OK);
      foreach (rows[i]) begin
         rows[i].cmd.millis = 32'hFFFF_FFF0 + i;
         rows[i].cmd.micros = 32'hFFFF_FF00 + 3 * i;
         send_word(rows[i].cmd, rows[i].known, rows[i].levels, rows[i].status);
      end
      req_tvalid <= 0;
      @(negedge clock);

      for (int n = 0; n < RANDOM_WORDS; ) begin
         int burst;
         burst = $urandom_range(1, 30);
         for (int b = 0; b < burst && n < RANDOM_WORDS; b++, n++)
            send_word(random_word(), 0, 0, ST_OK);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
         if (gap != 0) begin
            req_tvalid <= 0;
            repeat (gap) @(negedge clock);
         end
      end
      req_tvalid <= 0;
      stim_done = 1;
      while (level_queue.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (mismatches == 0 && level_queue.size() == 0)
         $display("multichannel_soft_pwm_blinker_unit regression: pass");
      else
         $display("multichannel_soft_pwm_blinker_unit regression: fail");
      $finish;
   end
endmodule
